// ===== rtl/mvm_pkg.sv =====
package mvm_pkg;

    // Item, result and configuration field widths
    localparam int DATA_W    = 32;
    localparam int ELEM_W    = 12;
    localparam int OP_W      = 2;
    localparam int RIDX_W    = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_LOAD_MAT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_VEC = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 2'd2;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic              valid;
        logic              first;     // first product of a result element
        logic              last_j;    // last product of a result element
        logic              last_out;  // last result element of the vector
        logic [RIDX_W-1:0] idx;       // result element position
    } t_tag;

endpackage

// ===== rtl/mvm_ram.sv =====
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mvm_seq.sv =====
module mvm_seq #(
    parameter int MAX_DIM = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [$clog2(MAX_DIM+1)-1:0]         i_rows,
    input  logic [$clog2(MAX_DIM+1)-1:0]         i_cols,
    input  logic                                 i_trans,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_mat_raddr,
    output logic [$clog2(MAX_DIM)-1:0]           o_vec_raddr,
    output mvm_pkg::t_tag                        o_tag,
    output logic                                 o_busy
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    logic          r_run;
    logic          r_trans;
    logic [DW-1:0] r_n_in;
    logic [DW-1:0] r_n_out;
    logic [DW-1:0] r_cols;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [AW-1:0] r_addr;
    mvm_pkg::t_tag r_tag;

    logic          last_j;
    logic          last_out;
    logic [AW-1:0] n_addr;

    // End of inner sum and end of result vector
    assign last_j   = (DW'(r_j) == (r_n_in - DW'(1)));
    assign last_out = last_j && (DW'(r_i) == (r_n_out - DW'(1)));

    // Row-major walk: consecutive in M*V, stride of cols in V*M
    always_comb begin
        if (!r_trans) begin
            n_addr = r_addr + AW'(1);
        end else if (last_j) begin
            n_addr = AW'(r_i) + AW'(1);
        end else begin
            n_addr = r_addr + AW'(r_cols);
        end
    end

    // Control: run flag and tag, valid reset only
    always_ff @(posedge i_clk) begin
        r_tag.first    <= (r_j == '0);
        r_tag.last_j   <= last_j;
        r_tag.last_out <= last_out;
        r_tag.idx      <= mvm_pkg::RIDX_W'(r_i);
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= r_run;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last_out) begin
                r_run <= 1'b0;
            end
        end
    end

    // Counters and addresses
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_trans <= i_trans;
            r_cols  <= i_cols;
            r_n_in  <= i_trans ? i_rows : i_cols;
            r_n_out <= i_trans ? i_cols : i_rows;
            r_i     <= '0;
            r_j     <= '0;
            r_addr  <= '0;
        end else if (r_run) begin
            r_addr <= n_addr;
            if (last_j) begin
                r_j <= '0;
                r_i <= r_i + IW'(1);
            end else begin
                r_j <= r_j + IW'(1);
            end
        end
    end

    assign o_mat_raddr = r_addr;
    assign o_vec_raddr = r_j;
    assign o_tag       = r_tag;
    assign o_busy      = r_run | r_tag.valid;

endmodule

// ===== rtl/mvm_mac.sv =====
module mvm_mac #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mvm_pkg::t_tag                       i_tag,
    input  logic signed [mvm_pkg::DATA_W-1:0]   i_mat,
    input  logic signed [mvm_pkg::DATA_W-1:0]   i_vec,
    output logic                                o_valid,
    output logic signed [mvm_pkg::DATA_W-1:0]   o_value,
    output logic [mvm_pkg::RIDX_W-1:0]          o_idx,
    output logic                                o_last,
    output logic                                o_busy
);

    localparam int PW   = 2 * mvm_pkg::DATA_W;
    localparam int ACCW = PW + $clog2(MAX_DIM);
    localparam logic [mvm_pkg::DATA_W-1:0] SAT_MAX = {1'b0, {(mvm_pkg::DATA_W-1){1'b1}}};
    localparam logic [mvm_pkg::DATA_W-1:0] SAT_MIN = {1'b1, {(mvm_pkg::DATA_W-1){1'b0}}};

    mvm_pkg::t_tag                      r_p2;
    logic signed [PW-1:0]               r_prod;
    logic signed [ACCW-1:0]             r_acc;
    logic                               r_done;
    logic                               r_done_last;
    logic [mvm_pkg::RIDX_W-1:0]         r_done_idx;
    logic                               r_out_valid;
    logic signed [mvm_pkg::DATA_W-1:0]  r_out_value;
    logic [mvm_pkg::RIDX_W-1:0]         r_out_idx;
    logic                               r_out_last;

    logic signed [ACCW-1:0]               shifted;
    logic [ACCW-mvm_pkg::DATA_W:0]        upper;
    logic signed [mvm_pkg::DATA_W-1:0]    sat_value;

    // Scale back and saturate the finished sum
    assign shifted = r_acc >>> FRAC_BITS;
    assign upper   = shifted[ACCW-1:mvm_pkg::DATA_W-1];

    always_comb begin
        if (!shifted[ACCW-1] && (|upper)) begin
            sat_value = SAT_MAX;
        end else if (shifted[ACCW-1] && !(&upper)) begin
            sat_value = SAT_MIN;
        end else begin
            sat_value = shifted[mvm_pkg::DATA_W-1:0];
        end
    end

    // Control: stage tag, stage valids and result strobe
    always_ff @(posedge i_clk) begin
        r_p2.first    <= i_tag.first;
        r_p2.last_j   <= i_tag.last_j;
        r_p2.last_out <= i_tag.last_out;
        r_p2.idx      <= i_tag.idx;
        if (!i_rst_n) begin
            r_p2.valid  <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p2.valid  <= i_tag.valid;
            r_done      <= r_p2.valid && r_p2.last_j;
            r_out_valid <= r_done;
        end
    end

    // Multiply, accumulate, result payload
    always_ff @(posedge i_clk) begin
        r_prod        <= i_mat * i_vec;
        if (r_p2.valid) begin
            r_acc <= r_p2.first ? ACCW'(r_prod) : r_acc + ACCW'(r_prod);
        end
        r_done_idx  <= r_p2.idx;
        r_done_last <= r_p2.last_out;
        r_out_value <= sat_value;
        r_out_idx   <= r_done_idx;
        r_out_last  <= r_done_last;
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_idx   = r_out_idx;
    assign o_last  = r_out_last;
    assign o_busy  = r_p2.valid | r_done;

endmodule

// ===== rtl/matrix_vector_multiply.sv =====
// Loads: one item per cycle while not busy, written at the accepting edge; busy
// stays low. Compute: N = n_out * n_in multiply-accumulates, one per cycle, set
// by the single shared MAC and the one read port of each store. A result follows
// each n_in products, through the accumulator and the saturating output register.
// Reset clears control and sets num_rows = num_cols = 64, transpose off;
// stores are not cleared. The receiver cannot stall results.
module matrix_vector_multiply #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mvm_pkg::OP_W-1:0]            i_op,
    input  logic [mvm_pkg::ELEM_W-1:0]          i_elem_index,
    input  logic signed [mvm_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_valid,
    output logic signed [mvm_pkg::DATA_W-1:0]   o_result_value,
    output logic [mvm_pkg::RIDX_W-1:0]          o_result_index,
    output logic                                o_last
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    logic [mvm_pkg::CFG_W-1:0] r_num_rows;
    logic [mvm_pkg::CFG_W-1:0] r_num_cols;
    logic                      r_transpose;

    logic                         accept;
    logic                         mat_we;
    logic                         vec_we;
    logic                         compute;
    logic [DW-1:0]                rows_c;
    logic [DW-1:0]                cols_c;
    logic [AW-1:0]                mat_raddr;
    logic [IW-1:0]                vec_raddr;
    logic [mvm_pkg::DATA_W-1:0]   mat_rdata;
    logic [mvm_pkg::DATA_W-1:0]   vec_rdata;
    mvm_pkg::t_tag                tag;
    logic                         seq_busy;
    logic                         mac_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= mvm_pkg::CFG_W'(64);
            r_num_cols  <= mvm_pkg::CFG_W'(64);
            r_transpose <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mvm_pkg::REG_NUM_ROWS:  r_num_rows  <= i_cfg_data;
                mvm_pkg::REG_NUM_COLS:  r_num_cols  <= i_cfg_data;
                mvm_pkg::REG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Dimensions clamped to 1..MAX_DIM
    always_comb begin
        if (r_num_rows == '0) begin
            rows_c = DW'(1);
        end else if (32'(r_num_rows) > 32'(MAX_DIM)) begin
            rows_c = DW'(MAX_DIM);
        end else begin
            rows_c = DW'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            cols_c = DW'(1);
        end else if (32'(r_num_cols) > 32'(MAX_DIM)) begin
            cols_c = DW'(MAX_DIM);
        end else begin
            cols_c = DW'(r_num_cols);
        end
    end

    // Item decode; out-of-range loads are dropped
    assign accept  = start && !busy;
    assign mat_we  = accept && (i_op == mvm_pkg::OP_LOAD_MAT)
                     && (32'(i_elem_index) < 32'(MAX_DIM * MAX_DIM));
    assign vec_we  = accept && (i_op == mvm_pkg::OP_LOAD_VEC)
                     && (32'(i_elem_index) < 32'(MAX_DIM));
    assign compute = accept && (i_op == mvm_pkg::OP_COMPUTE);

    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (AW'(i_elem_index)),
        .i_wdata (i_value),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (IW'(i_elem_index)),
        .i_wdata (i_value),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    mvm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (compute),
        .i_rows      (rows_c),
        .i_cols      (cols_c),
        .i_trans     (r_transpose),
        .o_mat_raddr (mat_raddr),
        .o_vec_raddr (vec_raddr),
        .o_tag       (tag),
        .o_busy      (seq_busy)
    );

    mvm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag),
        .i_mat   (mat_rdata),
        .i_vec   (vec_rdata),
        .o_valid (o_valid),
        .o_value (o_result_value),
        .o_idx   (o_result_index),
        .o_last  (o_last),
        .o_busy  (mac_busy)
    );

    assign busy = seq_busy | mac_busy;

    // A compute item keeps the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        compute |=> busy)
        else $error("compute item accepted but block not busy");

    // Final result of a vector is not followed at once by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result right after final element");

    // Results only come out of a running compute
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe while idle");

endmodule

// ===== tb/mvm_checker.sv =====
`timescale 1ns / 100ps

module mvm_checker #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [mvm_pkg::OP_W-1:0]          i_op,
    input  logic [mvm_pkg::ELEM_W-1:0]        i_elem_index,
    input  logic signed [mvm_pkg::DATA_W-1:0] i_value,
    input  logic                              i_cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    input  logic signed [mvm_pkg::DATA_W-1:0] i_result_value,
    input  logic [mvm_pkg::RIDX_W-1:0]        i_result_index,
    input  logic                              i_last,
    output int                                o_fail_count,
    output int                                o_pending
);

    typedef struct packed {
        logic signed [mvm_pkg::DATA_W-1:0] rval;
        logic [mvm_pkg::RIDX_W-1:0]        ridx;
        logic                              rlast;
    } t_elem;

    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

    // Model state
    logic signed [mvm_pkg::DATA_W-1:0] mat_mem [0:MAX_DIM*MAX_DIM-1];
    logic signed [mvm_pkg::DATA_W-1:0] vec_mem [0:MAX_DIM-1];
    logic [mvm_pkg::CFG_W-1:0]         rows_reg;
    logic [mvm_pkg::CFG_W-1:0]         cols_reg;
    logic                              transpose_reg;

    t_elem expected_elems [$];
    t_elem want;
    int    mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Out-of-range dimensions: 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic int unsigned eff_dim(input logic [mvm_pkg::CFG_W-1:0] d);
        if (d == 0) return 1;
        if (32'(d) > MAX_DIM) return MAX_DIM;
        return 32'(d);
    endfunction

    function automatic void flag_error(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mvm_checker: %0t ns: %s", $time, what);
    endfunction

    // Full-precision dot products, arithmetic shift, saturate to 32 bits
    function automatic void predict_result_vector();
        int unsigned rows, cols, n_out, n_in, i, j, mi;
        logic signed [127:0] acc;
        logic signed [127:0] scaled;
        longint prod;
        t_elem e;
        rows  = eff_dim(rows_reg);
        cols  = eff_dim(cols_reg);
        n_out = transpose_reg ? cols : rows;
        n_in  = transpose_reg ? rows : cols;
        for (i = 0; i < n_out; i++) begin
            acc = '0;
            for (j = 0; j < n_in; j++) begin
                mi   = transpose_reg ? (j * cols + i) : (i * cols + j);
                prod = longint'(mat_mem[mi]) * longint'(vec_mem[j]);
                acc  = acc + prod;
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > SAT_HI) begin
                e.rval = 32'h7FFF_FFFF;
            end else if (scaled < SAT_LO) begin
                e.rval = 32'h8000_0000;
            end else begin
                e.rval = scaled[mvm_pkg::DATA_W-1:0];
            end
            e.ridx  = i[mvm_pkg::RIDX_W-1:0];
            e.rlast = (i + 1 == n_out);
            expected_elems.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg      = 7'd64;
            cols_reg      = 7'd64;
            transpose_reg = 1'b0;
            expected_elems.delete();
            o_pending <= 0;
        end else begin
            // Result side: compare with the oldest expected element
            if (i_valid) begin
                if (expected_elems.size() == 0) begin
                    flag_error($sformatf("unexpected result: value %h index %0d last %0b",
                                         i_result_value, i_result_index, i_last));
                end else begin
                    want = expected_elems.pop_front();
                    if (i_result_value !== want.rval)
                        flag_error($sformatf("element %0d value: exp %h got %h",
                                             want.ridx, want.rval, i_result_value));
                    if (i_result_index !== want.ridx)
                        flag_error($sformatf("element index: exp %0d got %0d",
                                             want.ridx, i_result_index));
                    if (i_last !== want.rlast)
                        flag_error($sformatf("element %0d last: exp %0b got %0b",
                                             want.ridx, want.rlast, i_last));
                end
            end

            // Accepted item sees the registers as they were before this edge
            if (i_start && !i_busy) begin
                case (i_op)
                    mvm_pkg::OP_LOAD_MAT: begin
                        if (32'(i_elem_index) < MAX_DIM * MAX_DIM)
                            mat_mem[i_elem_index] = i_value;
                    end
                    mvm_pkg::OP_LOAD_VEC: begin
                        if (32'(i_elem_index) < MAX_DIM) vec_mem[i_elem_index] = i_value;
                    end
                    mvm_pkg::OP_COMPUTE:  predict_result_vector();
                    default: ;
                endcase
            end

            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mvm_pkg::REG_NUM_ROWS:  rows_reg = i_cfg_data;
                    mvm_pkg::REG_NUM_COLS:  cols_reg = i_cfg_data;
                    mvm_pkg::REG_TRANSPOSE: transpose_reg = i_cfg_data[0];
                    default: ;
                endcase
            end

            o_pending <= expected_elems.size();
        end
    end

endmodule

// ===== tb/matrix_vector_multiply_tb.sv =====
`timescale 1ns / 100ps

module matrix_vector_multiply_tb;

    localparam int MAX_DIM        = 64;
    localparam int FRAC_BITS      = 16;
    localparam int TOTAL_ITEMS    = 370;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Op code the block leaves unused
    localparam logic [mvm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              start        = 1'b0;
    logic [mvm_pkg::OP_W-1:0]          i_op         = mvm_pkg::OP_LOAD_MAT;
    logic [mvm_pkg::ELEM_W-1:0]        i_elem_index = '0;
    logic signed [mvm_pkg::DATA_W-1:0] i_value      = '0;
    logic                              i_cfg_we     = 1'b0;
    logic [mvm_pkg::CFG_IDX_W-1:0]     i_cfg_index  = mvm_pkg::REG_NUM_ROWS;
    logic [mvm_pkg::CFG_W-1:0]         i_cfg_data   = '0;
    logic                              busy;
    logic                              o_valid;
    logic signed [mvm_pkg::DATA_W-1:0] o_result_value;
    logic [mvm_pkg::RIDX_W-1:0]        o_result_index;
    logic                              o_last;

    int fail_count;
    int pending;

    // Stimulus-side bookkeeping
    bit          mat_written [0:MAX_DIM*MAX_DIM-1];
    bit          vec_written [0:MAX_DIM-1];
    int unsigned cur_rows = 64;
    int unsigned cur_cols = 64;
    bit          cur_mode = 1'b0;
    int          burst_left = 0;
    int          item_count = 0;
    int          quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    matrix_vector_multiply #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_elem_index   (i_elem_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_result_index (o_result_index),
        .o_last         (o_last)
    );

    mvm_checker #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_elem_index   (i_elem_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (o_valid),
        .i_result_value (o_result_value),
        .i_result_index (o_result_index),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Watchdog: too long without any item, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned used_dim(input logic [mvm_pkg::CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (32'(raw) > MAX_DIM) return MAX_DIM;
        return 32'(raw);
    endfunction

    // Mostly small sizes, now and then large or out of range
    function automatic logic [mvm_pkg::CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 23))
            0:       return '0;
            1:       return mvm_pkg::CFG_W'($urandom_range(MAX_DIM + 1, 127));
            2:       return mvm_pkg::CFG_W'($urandom_range(9, MAX_DIM));
            default: return mvm_pkg::CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Mix of full-range, moderate Q16.16 and corner values
    function automatic logic [mvm_pkg::DATA_W-1:0] rand_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0, 1:    return r;
            2, 3, 4: return {{11{r[20]}}, r[20:0]};
            5: begin
                case (r[2:0])
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0001_0000;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return {{7{r[24]}}, r[24:0]};
        endcase
    endfunction

    // One item; the sender runs in bursts with idle gaps between them
    task automatic send_item(input logic [mvm_pkg::OP_W-1:0] op, input int unsigned idx,
                             input logic [mvm_pkg::DATA_W-1:0] val);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_elem_index <= idx[mvm_pkg::ELEM_W-1:0];
        i_value      <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        item_count++;
        case (op)
            mvm_pkg::OP_LOAD_MAT: mat_written[idx[mvm_pkg::ELEM_W-1:0]] = 1'b1;
            mvm_pkg::OP_LOAD_VEC: begin
                if (idx[mvm_pkg::ELEM_W-1:0] < MAX_DIM)
                    vec_written[idx[mvm_pkg::ELEM_W-1:0]] = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic send_compute();
        send_item(mvm_pkg::OP_COMPUTE, $urandom, $urandom);
    endtask

    // Let every pending result drain and the block go quiet
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle
    task automatic set_config(input logic [mvm_pkg::CFG_W-1:0] rows_raw,
                              input logic [mvm_pkg::CFG_W-1:0] cols_raw, input bit mode);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mvm_pkg::REG_NUM_ROWS;
        i_cfg_data  <= rows_raw;
        @(posedge i_clk);
        i_cfg_index <= mvm_pkg::REG_NUM_COLS;
        i_cfg_data  <= cols_raw;
        @(posedge i_clk);
        i_cfg_index <= mvm_pkg::REG_TRANSPOSE;
        i_cfg_data  <= {{(mvm_pkg::CFG_W-1){1'b0}}, mode};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_rows = used_dim(rows_raw);
        cur_cols = used_dim(cols_raw);
        cur_mode = mode;
    endtask

    // Ignored ops, out-of-range vector loads and stray loads
    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: send_item(OP_UNUSED, $urandom_range(0, 4095), $urandom);
            1: send_item(mvm_pkg::OP_LOAD_VEC, $urandom_range(MAX_DIM, 4095), rand_value());
            2: send_item(mvm_pkg::OP_LOAD_VEC, $urandom_range(0, MAX_DIM - 1), rand_value());
            default: send_item(mvm_pkg::OP_LOAD_MAT, $urandom_range(0, 4095), rand_value());
        endcase
    endtask

    // Write whatever the next compute reads and has never been written
    task automatic fill_operands();
        int unsigned k, n_in;
        n_in = cur_mode ? cur_rows : cur_cols;
        for (k = 0; k < cur_rows * cur_cols; k++)
            if (!mat_written[k]) send_item(mvm_pkg::OP_LOAD_MAT, k, rand_value());
        for (k = 0; k < n_in; k++)
            if (!vec_written[k]) send_item(mvm_pkg::OP_LOAD_VEC, k, rand_value());
    endtask

    // Fresh matrix and vector for the active size, with some noise mixed in
    task automatic load_region();
        int unsigned k, n_in, pass, vec_pass;
        n_in     = cur_mode ? cur_rows : cur_cols;
        vec_pass = $urandom_range(0, 1);
        for (pass = 0; pass < 2; pass++) begin
            if (pass == vec_pass) begin
                for (k = 0; k < n_in; k++) begin
                    if ($urandom_range(0, 9) == 0) noise_item();
                    send_item(mvm_pkg::OP_LOAD_VEC, k, rand_value());
                end
            end else begin
                for (k = 0; k < cur_rows * cur_cols; k++) begin
                    if ($urandom_range(0, 9) == 0) noise_item();
                    send_item(mvm_pkg::OP_LOAD_MAT, k, rand_value());
                end
            end
        end
    endtask

    initial begin
        logic [mvm_pkg::CFG_W-1:0] rows_raw, cols_raw;
        int unsigned n_in;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single element: saturation both ways, rounding toward minus infinity
        set_config(7'd1, 7'd1, 1'b0);
        send_item(mvm_pkg::OP_LOAD_MAT, 0, 32'h7FFF_FFFF);
        send_item(mvm_pkg::OP_LOAD_VEC, 0, 32'h7FFF_FFFF);
        send_compute();
        send_item(mvm_pkg::OP_LOAD_MAT, 0, 32'h8000_0000);
        send_compute();
        send_item(mvm_pkg::OP_LOAD_VEC, 0, 32'h8000_0000);
        send_compute();
        send_item(mvm_pkg::OP_LOAD_MAT, 0, 32'hFFFF_FFFF);
        send_item(mvm_pkg::OP_LOAD_VEC, 0, 32'h0000_0001);
        send_compute();

        // Unused op and out-of-range vector loads must leave the stores alone
        send_item(OP_UNUSED, 4095, 32'hFFFF_FFFF);
        send_item(mvm_pkg::OP_LOAD_VEC, 4095, 32'h1234_5678);
        send_item(mvm_pkg::OP_LOAD_VEC, MAX_DIM, 32'h7654_3210);
        send_item(mvm_pkg::OP_LOAD_MAT, 4095, 32'h0001_0000);
        send_compute();

        // Small transposed case
        wait_idle();
        set_config(7'd2, 7'd2, 1'b1);
        send_item(mvm_pkg::OP_LOAD_MAT, 0, 32'h0001_0000);
        send_item(mvm_pkg::OP_LOAD_MAT, 1, 32'h0002_0000);
        send_item(mvm_pkg::OP_LOAD_MAT, 2, 32'hFFFD_0000);
        send_item(mvm_pkg::OP_LOAD_MAT, 3, 32'h0004_8000);
        send_item(mvm_pkg::OP_LOAD_VEC, 0, 32'h0000_8000);
        send_item(mvm_pkg::OP_LOAD_VEC, 1, 32'hFFFF_0000);
        send_compute();

        // Dimension extremes, including 0 and above the maximum
        wait_idle();
        set_config(7'd0, 7'd127, 1'b0);
        fill_operands();
        send_compute();
        wait_idle();
        set_config(7'd127, 7'd0, 1'b1);
        fill_operands();
        send_compute();
        wait_idle();
        set_config(7'd64, 7'd1, 1'b0);
        fill_operands();
        send_compute();
        wait_idle();
        set_config(7'd1, 7'd64, 1'b1);
        fill_operands();
        send_compute();

        // Random phases until the item budget is used: mostly load-then-compute
        while (item_count < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                rows_raw = pick_dim();
                cols_raw = pick_dim();
                if (used_dim(rows_raw) > 8) begin
                    cols_raw = mvm_pkg::CFG_W'($urandom_range(1, 2));
                end else if (used_dim(cols_raw) > 8) begin
                    rows_raw = mvm_pkg::CFG_W'($urandom_range(1, 2));
                end
                wait_idle();
                set_config(rows_raw, cols_raw, 1'($urandom_range(0, 1)));
                load_region();
                send_compute();
                // Touch a few operands and recompute behind the running one
                if ($urandom_range(0, 2) == 0) begin
                    n_in = cur_mode ? cur_rows : cur_cols;
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1))
                            send_item(mvm_pkg::OP_LOAD_MAT,
                                      $urandom_range(0, cur_rows * cur_cols - 1),
                                      rand_value());
                        else
                            send_item(mvm_pkg::OP_LOAD_VEC, $urandom_range(0, n_in - 1),
                                      rand_value());
                    end
                    send_compute();
                end
            end else begin
                repeat ($urandom_range(5, 20)) noise_item();
                fill_operands();
                send_compute();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== matrix_vector_multiply.f =====
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_seq.sv
rtl/mvm_mac.sv
rtl/matrix_vector_multiply.sv
tb/mvm_checker.sv
tb/matrix_vector_multiply_tb.sv
